[hdl/dik_pkg.sv]
// ----------------------------------------------------------------------------
// dik_pkg
// Shared types, register indexes, constants and the CORDIC angle table for
// the delta robot inverse kinematics block.
// ----------------------------------------------------------------------------
package dik_pkg;

  // Widths of the fixed-point fields
  localparam int unsigned COORD_W = 24;
  localparam int unsigned LEN_W   = 23;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned WIN_W   = 32;

  // Configuration register indexes
  localparam logic [2:0] REG_UPPER_LEG = 3'd0;
  localparam logic [2:0] REG_LOWER_LEG = 3'd1;
  localparam logic [2:0] REG_OFFSET_A  = 3'd2;
  localparam logic [2:0] REG_OFFSET_B  = 3'd3;
  localparam logic [2:0] REG_OFFSET_C  = 3'd4;
  localparam logic [2:0] REG_WIN0      = 3'd5;
  localparam logic [2:0] REG_WIN1      = 3'd6;
  localparam logic [2:0] REG_WIN2      = 3'd7;

  // Window reset: minimum 0, maximum all ones
  localparam logic [31:0] WIN_RESET = 32'hFFFF_0000;

  // sqrt(3) in Q16
  localparam logic signed [31:0] SQRT3_Q16 = 32'sd113512;

  // Last CORDIC iteration and last square root iteration
  localparam logic [4:0] CORDIC_LAST = 5'd15;
  localparam logic [4:0] SQRT_LAST   = 5'd31;

  typedef struct packed {
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_0;
    logic [ANGLE_W-1:0] angle_1;
    logic [ANGLE_W-1:0] angle_2;
    logic [2:0]         updated_mask;
    logic [2:0]         second_root_mask;
    logic [2:0]         unreachable_mask;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COMMON,
    ST_COEF,
    ST_NORM,
    ST_SQUARE,
    ST_SQRT,
    ST_CINIT,
    ST_CORDIC,
    ST_PICK,
    ST_DONE
  } state_t;

  // atan(2^-i) in 2^32 units per turn
  function automatic logic [31:0] atan_turn(input logic [3:0] i);
    logic [31:0] v;
    case (i)
      4'd0:    v = 32'd536870912;
      4'd1:    v = 32'd316933406;
      4'd2:    v = 32'd167458907;
      4'd3:    v = 32'd85004756;
      4'd4:    v = 32'd42667331;
      4'd5:    v = 32'd21354465;
      4'd6:    v = 32'd10679838;
      4'd7:    v = 32'd5340245;
      4'd8:    v = 32'd2670163;
      4'd9:    v = 32'd1335087;
      4'd10:   v = 32'd667544;
      4'd11:   v = 32'd333772;
      4'd12:   v = 32'd166886;
      4'd13:   v = 32'd83443;
      4'd14:   v = 32'd41722;
      default: v = 32'd20861;
    endcase
    return v;
  endfunction

endpackage

[hdl/delta_inverse_kinematics_top.sv]
// ----------------------------------------------------------------------------
// delta_inverse_kinematics_top
// Inverse kinematics of a three-arm rotary delta robot on one shared
// multiplier, one square root iteration unit and one CORDIC stage.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall / in_item) carries a target point
//   in Q15.8 mm. The result channel (out_valid / out_stall / out_item) carries
//   the three joint angles and the per-joint updated, second-root and
//   unreachable flags. The cfg_ port writes the leg lengths, offsets and
//   joint windows; write it only while the block is idle.
//   An item runs from its transfer through the common products, then per joint
//   the coefficients, normalization, squares and, for a reachable joint,
//   32 square root iterations and one or two CORDIC passes, and last the load
//   of the output register. The next item can be taken at the earliest in the
//   cycle after that load. The single 32x32 multiplier, the one-bit per-cycle
//   square root and the one-step-per-cycle CORDIC keep these steps in sequence.
//   in_stall is high from the transfer of an item until its result has been
//   written to the output register. A result waiting under out_stall does
//   not block the next input transfer; a finished item waits only when the
//   output register is still full.
//   Reset clears the joint angles to zero, the lengths and offsets to zero,
//   and opens every joint window to the full turn.
// ----------------------------------------------------------------------------
module delta_inverse_kinematics_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dik_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output dik_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  // Configuration
  logic        [22:0] ul_r, ll_r;
  logic signed [23:0] oa_r, ob_r, oc_r;
  logic        [31:0] win_r [3];

  // Control
  dik_pkg::state_t state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic [1:0] joint_r, joint_nxt;
  logic       pass_r, pass_nxt;

  // Datapath
  logic signed [23:0] px_r, py_r, pz_r, px_nxt, py_nxt, pz_nxt;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r, acc_nxt, base_r, base_nxt, cf_r, cf_nxt;
  logic signed [31:0] u_r, u_nxt;
  logic signed [63:0] e_r, f_r, g_r, e_nxt, f_nxt, g_nxt;
  logic        [63:0] mag_r, mag_nxt;
  logic        [63:0] sq_n_r, sq_res_r, sq_bit_r, sq_n_nxt, sq_res_nxt, sq_bit_nxt;
  logic signed [39:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic        [31:0] cacc_r, cacc_nxt;
  logic        [2:0]  upd_r, sec_r, unr_r, upd_nxt, sec_nxt, unr_nxt;
  logic        [15:0] ang_r [3];
  logic        [15:0] ang_nxt [3];
  dik_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Derived sums
  logic signed [24:0] sa, s1, s2, tc, s_j;
  logic signed [31:0] ul32, ll32;
  logic signed [63:0] rnd, rnd_sh, t_val, ce_val;
  logic        [63:0] abs_e, abs_f, abs_g, mag_max, sq_trial;
  logic signed [39:0] x0, y0, r40, dx, dy;
  logic        [31:0] win_sel, ang_t, ang_rnd;
  logic        [15:0] cand;

  // Conditions used by the next-state and datapath control blocks
  logic in_xfer, mag_big, t_neg, win_hit, last_joint, out_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ul_r     <= '0;
      ll_r     <= '0;
      oa_r     <= '0;
      ob_r     <= '0;
      oc_r     <= '0;
      win_r[0] <= dik_pkg::WIN_RESET;
      win_r[1] <= dik_pkg::WIN_RESET;
      win_r[2] <= dik_pkg::WIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dik_pkg::REG_UPPER_LEG: ul_r     <= cfg_wdata[22:0];
        dik_pkg::REG_LOWER_LEG: ll_r     <= cfg_wdata[22:0];
        dik_pkg::REG_OFFSET_A:  oa_r     <= cfg_wdata[23:0];
        dik_pkg::REG_OFFSET_B:  ob_r     <= cfg_wdata[23:0];
        dik_pkg::REG_OFFSET_C:  oc_r     <= cfg_wdata[23:0];
        dik_pkg::REG_WIN0:      win_r[0] <= cfg_wdata;
        dik_pkg::REG_WIN1:      win_r[1] <= cfg_wdata;
        dik_pkg::REG_WIN2:      win_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Geometry sums
  assign sa   = {py_r[23], py_r} + {oa_r[23], oa_r};
  assign s1   = {px_r[23], px_r} + {ob_r[23], ob_r};
  assign s2   = {px_r[23], px_r} - {ob_r[23], ob_r};
  assign tc   = {py_r[23], py_r} + {oc_r[23], oc_r};
  assign s_j  = (joint_r == 2'd1) ? s1 : s2;
  assign ul32 = {9'd0, ul_r};
  assign ll32 = {9'd0, ll_r};

  // Rounded sqrt(3) product
  assign rnd    = prod_r + 64'sd32768;
  assign rnd_sh = rnd >>> 16;

  // Coefficient E for the current joint
  always_comb begin
    case (joint_r)
      2'd0:    ce_val = prod_r <<< 1;
      2'd1:    ce_val = -prod_r;
      default: ce_val = prod_r;
    endcase
  end

  // Largest magnitude of the three coefficients
  assign abs_e   = e_r[63] ? 64'(-e_r) : 64'(e_r);
  assign abs_f   = f_r[63] ? 64'(-f_r) : 64'(f_r);
  assign abs_g   = g_r[63] ? 64'(-g_r) : 64'(g_r);
  always_comb begin
    mag_max = abs_e;
    if (abs_f > mag_max) mag_max = abs_f;
    if (abs_g > mag_max) mag_max = abs_g;
  end
  assign mag_big = (mag_r[63:30] != '0);

  // T = E^2 + F^2 - G^2
  assign t_val = acc_r - prod_r;
  assign t_neg = t_val[63];

  // Square root trial
  assign sq_trial = sq_res_r + sq_bit_r;

  // CORDIC start vector
  assign r40 = {8'd0, sq_res_r[31:0]};
  assign x0  = {{8{g_r[31]}}, g_r[31:0]} - {{8{e_r[31]}}, e_r[31:0]};
  assign y0  = pass_r ? (-{{8{f_r[31]}}, f_r[31:0]} - r40)
                      : (-{{8{f_r[31]}}, f_r[31:0]} + r40);
  assign dx  = cy_r >>> step_r[3:0];
  assign dy  = cx_r >>> step_r[3:0];

  // Candidate angle and window test
  always_comb begin
    case (joint_r)
      2'd1:    win_sel = win_r[1];
      2'd2:    win_sel = win_r[2];
      default: win_sel = win_r[0];
    endcase
  end
  assign ang_t   = {cacc_r[30:0], 1'b0} + 32'h4000_0000;
  assign ang_rnd = ang_t + 32'h0000_8000;
  assign cand    = ang_rnd[31:16];
  assign win_hit = (cand >= win_sel[15:0]) && (cand <= win_sel[31:16]);

  assign in_xfer    = in_valid && !in_stall;
  assign last_joint = (joint_r == 2'd2);
  assign out_free   = !out_valid_r || !out_stall;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      dik_pkg::ST_COMMON: begin
        case (step_r)
          5'd0: begin mul_a = ul32; mul_b = ul32; end
          5'd1: begin mul_a = ll32; mul_b = ll32; end
          5'd2: begin mul_a = 32'(pz_r); mul_b = 32'(pz_r); end
          5'd3: begin mul_a = 32'(pz_r); mul_b = ul32; end
          default: ;
        endcase
      end
      dik_pkg::ST_COEF: begin
        case (step_r)
          5'd0: begin
            if (joint_r == 2'd0) begin
              mul_a = 32'(px_r); mul_b = 32'(px_r);
            end else begin
              mul_a = 32'(s_j); mul_b = dik_pkg::SQRT3_Q16;
            end
          end
          5'd1: begin
            if (joint_r == 2'd0) begin
              mul_a = 32'(sa); mul_b = 32'(sa);
            end else begin
              mul_a = 32'(s_j); mul_b = 32'(s_j);
            end
          end
          5'd2: begin
            if (joint_r != 2'd0) begin
              mul_a = 32'(tc); mul_b = 32'(tc);
            end
          end
          5'd3: begin
            mul_a = ul32;
            mul_b = (joint_r == 2'd0) ? 32'(sa) : u_r;
          end
          default: ;
        endcase
      end
      dik_pkg::ST_SQUARE: begin
        case (step_r)
          5'd0: begin mul_a = e_r[31:0]; mul_b = e_r[31:0]; end
          5'd1: begin mul_a = f_r[31:0]; mul_b = f_r[31:0]; end
          5'd2: begin mul_a = g_r[31:0]; mul_b = g_r[31:0]; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dik_pkg::ST_IDLE:   if (in_xfer) state_nxt = dik_pkg::ST_COMMON;
      dik_pkg::ST_COMMON: if (step_r == 5'd4) state_nxt = dik_pkg::ST_COEF;
      dik_pkg::ST_COEF:   if (step_r == 5'd4) state_nxt = dik_pkg::ST_NORM;
      dik_pkg::ST_NORM:   if (step_r != 5'd0 && !mag_big) state_nxt = dik_pkg::ST_SQUARE;
      dik_pkg::ST_SQUARE: begin
        if (step_r == 5'd3) begin
          if (!t_neg) state_nxt = dik_pkg::ST_SQRT;
          else if (last_joint) state_nxt = dik_pkg::ST_DONE;
          else state_nxt = dik_pkg::ST_COEF;
        end
      end
      dik_pkg::ST_SQRT:   if (step_r == dik_pkg::SQRT_LAST) state_nxt = dik_pkg::ST_CINIT;
      dik_pkg::ST_CINIT:  state_nxt = dik_pkg::ST_CORDIC;
      dik_pkg::ST_CORDIC: if (step_r == dik_pkg::CORDIC_LAST) state_nxt = dik_pkg::ST_PICK;
      dik_pkg::ST_PICK: begin
        if (win_hit || pass_r) begin
          state_nxt = last_joint ? dik_pkg::ST_DONE : dik_pkg::ST_COEF;
        end else begin
          state_nxt = dik_pkg::ST_CINIT;
        end
      end
      dik_pkg::ST_DONE:   if (out_free) state_nxt = dik_pkg::ST_IDLE;
      default:            state_nxt = dik_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output updates
  always_comb begin
    step_nxt      = (state_nxt != state_r) ? 5'd0 : step_r + 5'd1;
    joint_nxt     = joint_r;
    pass_nxt      = pass_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pz_nxt        = pz_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    cf_nxt        = cf_r;
    u_nxt         = u_r;
    e_nxt         = e_r;
    f_nxt         = f_r;
    g_nxt         = g_r;
    mag_nxt       = mag_r;
    sq_n_nxt      = sq_n_r;
    sq_res_nxt    = sq_res_r;
    sq_bit_nxt    = sq_bit_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cacc_nxt      = cacc_r;
    upd_nxt       = upd_r;
    sec_nxt       = sec_r;
    unr_nxt       = unr_r;
    ang_nxt       = ang_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      // Latch the target and clear the flags
      dik_pkg::ST_IDLE: begin
        if (in_xfer) begin
          px_nxt    = in_item.target_x;
          py_nxt    = in_item.target_y;
          pz_nxt    = in_item.target_z;
          joint_nxt = 2'd0;
          upd_nxt   = '0;
          sec_nxt   = '0;
          unr_nxt   = '0;
        end
      end
      // L^2 - l^2 + z^2 and F = 2 z L
      dik_pkg::ST_COMMON: begin
        case (step_r)
          5'd1: acc_nxt  = prod_r;
          5'd2: acc_nxt  = acc_r - prod_r;
          5'd3: base_nxt = acc_r + prod_r;
          5'd4: cf_nxt   = prod_r <<< 1;
          default: ;
        endcase
      end
      // E and G of the current joint
      dik_pkg::ST_COEF: begin
        case (step_r)
          5'd1: begin
            if (joint_r == 2'd0) begin
              acc_nxt = base_r + prod_r;
            end else begin
              acc_nxt = base_r;
              u_nxt   = (joint_r == 2'd1) ? (rnd_sh[31:0] + 32'(tc))
                                          : (rnd_sh[31:0] - 32'(tc));
            end
          end
          5'd2, 5'd3: acc_nxt = acc_r + prod_r;
          5'd4: begin
            e_nxt = ce_val;
            f_nxt = cf_r;
            g_nxt = acc_r;
          end
          default: ;
        endcase
      end
      // Shift E, F, G down until the largest magnitude fits 30 bits
      dik_pkg::ST_NORM: begin
        if (step_r == 5'd0) begin
          mag_nxt  = mag_max;
          step_nxt = 5'd1;
        end else if (mag_big) begin
          e_nxt    = e_r >>> 1;
          f_nxt    = f_r >>> 1;
          g_nxt    = g_r >>> 1;
          mag_nxt  = mag_r >> 1;
          step_nxt = 5'd1;
        end
      end
      // Sum of squares, flag an out-of-reach joint
      dik_pkg::ST_SQUARE: begin
        case (step_r)
          5'd1: acc_nxt = prod_r;
          5'd2: acc_nxt = acc_r + prod_r;
          5'd3: begin
            if (t_neg) begin
              unr_nxt[joint_r] = 1'b1;
              joint_nxt        = joint_r + 2'd1;
            end else begin
              sq_n_nxt   = t_val;
              sq_res_nxt = '0;
              sq_bit_nxt = 64'h4000_0000_0000_0000;
            end
          end
          default: ;
        endcase
      end
      // One root bit per cycle
      dik_pkg::ST_SQRT: begin
        if (sq_n_r >= sq_trial) begin
          sq_n_nxt   = sq_n_r - sq_trial;
          sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
        pass_nxt   = 1'b0;
      end
      // Load the vector, fold a negative x by a half turn
      dik_pkg::ST_CINIT: begin
        if (x0[39]) begin
          cx_nxt   = -x0;
          cy_nxt   = -y0;
          cacc_nxt = 32'h8000_0000;
        end else begin
          cx_nxt   = x0;
          cy_nxt   = y0;
          cacc_nxt = '0;
        end
      end
      // Vectoring step, hold once y reaches zero
      dik_pkg::ST_CORDIC: begin
        if (cy_r[39]) begin
          cx_nxt   = cx_r - dx;
          cy_nxt   = cy_r + dy;
          cacc_nxt = cacc_r - dik_pkg::atan_turn(step_r[3:0]);
        end else if (cy_r != '0) begin
          cx_nxt   = cx_r + dx;
          cy_nxt   = cy_r - dy;
          cacc_nxt = cacc_r + dik_pkg::atan_turn(step_r[3:0]);
        end
      end
      // Take the root if it fits the window, else try the other one
      dik_pkg::ST_PICK: begin
        if (win_hit) begin
          ang_nxt[joint_r] = cand;
          upd_nxt[joint_r] = 1'b1;
          sec_nxt[joint_r] = pass_r;
        end
        if (win_hit || pass_r) begin
          joint_nxt = joint_r + 2'd1;
        end else begin
          pass_nxt = 1'b1;
        end
      end
      // Transfer the result into the output register
      dik_pkg::ST_DONE: begin
        if (out_free) begin
          out_nxt.angle_0          = ang_r[0];
          out_nxt.angle_1          = ang_r[1];
          out_nxt.angle_2          = ang_r[2];
          out_nxt.updated_mask     = upd_r;
          out_nxt.second_root_mask = sec_r;
          out_nxt.unreachable_mask = unr_r;
          out_valid_nxt            = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dik_pkg::ST_IDLE;
      step_r      <= '0;
      joint_r     <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ang_r[0]    <= '0;
      ang_r[1]    <= '0;
      ang_r[2]    <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      joint_r     <= joint_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
      ang_r       <= ang_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r   <= mul_a * mul_b;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    pz_r     <= pz_nxt;
    acc_r    <= acc_nxt;
    base_r   <= base_nxt;
    cf_r     <= cf_nxt;
    u_r      <= u_nxt;
    e_r      <= e_nxt;
    f_r      <= f_nxt;
    g_r      <= g_nxt;
    mag_r    <= mag_nxt;
    sq_n_r   <= sq_n_nxt;
    sq_res_r <= sq_res_nxt;
    sq_bit_r <= sq_bit_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    cacc_r   <= cacc_nxt;
    upd_r    <= upd_nxt;
    sec_r    <= sec_nxt;
    unr_r    <= unr_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall  = (state_r != dik_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

[dv/delta_inverse_kinematics_top_tb.sv]
// ----------------------------------------------------------------------------
// delta_inverse_kinematics_top_tb
// Self-checking bench for the delta robot inverse kinematics block: random
// and directed target points under several geometries and joint windows,
// each result checked against a bit-exact predictor held in the bench.
// ----------------------------------------------------------------------------
module delta_inverse_kinematics_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned DRAIN_CYCLES = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  dik_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  dik_pkg::out_item_t out_item;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;

  delta_inverse_kinematics_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Predictor state and geometry
  longint      geo_upper, geo_lower, geo_oa, geo_ob, geo_oc;
  logic [31:0] geo_win [3];
  logic [15:0] held_angle [3];

  dik_pkg::in_item_t  point_q [$];
  dik_pkg::out_item_t angle_q [$];
  int        sender_idle_pct = 0;
  int        stall_pct = 0;
  int        mismatches = 0;
  int unsigned cycles = 0;

  // Arithmetic shift right with floor
  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] atan_step(int i);
    case (i)
      0: return 32'd536870912;   1: return 32'd316933406;
      2: return 32'd167458907;   3: return 32'd85004756;
      4: return 32'd42667331;    5: return 32'd21354465;
      6: return 32'd10679838;    7: return 32'd5340245;
      8: return 32'd2670163;     9: return 32'd1335087;
      10: return 32'd667544;     11: return 32'd333772;
      12: return 32'd166886;     13: return 32'd83443;
      14: return 32'd41722;      default: return 32'd20861;
    endcase
  endfunction

  // Candidate joint angle: 2*atan2(y, x) + quarter turn, rounded to 16 bits
  function automatic logic [15:0] candidate_angle(longint y, longint x);
    logic [31:0] acc;
    logic [31:0] t;
    logic [32:0] r;
    longint dx, dy;
    acc = 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h8000_0000;
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; acc += atan_step(i);
      end else if (y < 0) begin
        x -= dx; y += dy; acc -= atan_step(i);
      end
    end
    t = 32'(acc * 2) + 32'h4000_0000;
    r = ({1'b0, t} + 33'h8000) >> 16;
    return r[15:0];
  endfunction

  function automatic bit fits_window(logic [15:0] ang, logic [31:0] win);
    return ang >= win[15:0] && ang <= win[31:16];
  endfunction

  // Solve one joint; returns {unreachable, second root, updated}
  function automatic logic [2:0] solve_joint(int j, longint ce, longint cf, longint cg);
    longint m, e, f, g, t, r;
    int k;
    logic [15:0] cand;
    m = abs64(ce);
    if (abs64(cf) > m) m = abs64(cf);
    if (abs64(cg) > m) m = abs64(cg);
    k = 0;
    while ((m >> k) >= (longint'(1) << 30)) k++;
    e = floor_shr(ce, k);
    f = floor_shr(cf, k);
    g = floor_shr(cg, k);
    t = e * e + f * f - g * g;
    if (t < 0) return 3'b100;
    r = int_sqrt(t);
    cand = candidate_angle(-f + r, g - e);
    if (fits_window(cand, geo_win[j])) begin
      held_angle[j] = cand;
      return 3'b001;
    end
    cand = candidate_angle(-f - r, g - e);
    if (fits_window(cand, geo_win[j])) begin
      held_angle[j] = cand;
      return 3'b011;
    end
    return 3'b000;
  endfunction

  function automatic dik_pkg::out_item_t solve_point(dik_pkg::in_item_t p);
    longint px, py, pz, zz, lsq, sa, s1, s2, tc, cf, u1, u2;
    logic [2:0] f0, f1, f2;
    dik_pkg::out_item_t o;
    px = p.target_x;
    py = p.target_y;
    pz = p.target_z;
    zz = pz * pz;
    lsq = geo_upper * geo_upper - geo_lower * geo_lower;
    sa = py + geo_oa;
    s1 = px + geo_ob;
    s2 = px - geo_ob;
    tc = py + geo_oc;
    cf = 2 * pz * geo_upper;
    u1 = floor_shr(s1 * 113512 + 32768, 16) + tc;
    u2 = floor_shr(s2 * 113512 + 32768, 16) - tc;
    f0 = solve_joint(0, 2 * geo_upper * sa, cf, px * px + sa * sa + zz + lsq);
    f1 = solve_joint(1, -geo_upper * u1, cf, s1 * s1 + tc * tc + zz + lsq);
    f2 = solve_joint(2, geo_upper * u2, cf, s2 * s2 + tc * tc + zz + lsq);
    o.angle_0 = held_angle[0];
    o.angle_1 = held_angle[1];
    o.angle_2 = held_angle[2];
    o.updated_mask     = {f2[0], f1[0], f0[0]};
    o.second_root_mask = {f2[1], f1[1], f0[1]};
    o.unreachable_mask = {f2[2], f1[2], f0[2]};
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // Input transfer seen at the last rising edge
  logic in_taken;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // Driver: present queued points, idle at random between transfers
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold payload while not yet taken
    end else if (point_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
      in_item <= point_q[0];
      angle_q.push_back(solve_point(point_q[0]));
      void'(point_q.pop_front());
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Monitor: check each result transfer against the oldest expectation
  always @(posedge clk) begin
    dik_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (angle_q.size() == 0) begin
        report_mismatch("unexpected result", longint'(out_item), 0);
      end else begin
        want = angle_q.pop_front();
        if (out_item.angle_0 !== want.angle_0)
          report_mismatch("angle_0", out_item.angle_0, want.angle_0);
        if (out_item.angle_1 !== want.angle_1)
          report_mismatch("angle_1", out_item.angle_1, want.angle_1);
        if (out_item.angle_2 !== want.angle_2)
          report_mismatch("angle_2", out_item.angle_2, want.angle_2);
        if (out_item.updated_mask !== want.updated_mask)
          report_mismatch("updated_mask", out_item.updated_mask, want.updated_mask);
        if (out_item.second_root_mask !== want.second_root_mask)
          report_mismatch("second_root_mask", out_item.second_root_mask,
                          want.second_root_mask);
        if (out_item.unreachable_mask !== want.unreachable_mask)
          report_mismatch("unreachable_mask", out_item.unreachable_mask,
                          want.unreachable_mask);
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Wait until every queued point is sent and every result checked
  task automatic drain();
    while (point_q.size() != 0 || in_valid || angle_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dik_pkg::REG_UPPER_LEG: geo_upper = longint'(val[22:0]);
      dik_pkg::REG_LOWER_LEG: geo_lower = longint'(val[22:0]);
      dik_pkg::REG_OFFSET_A:  geo_oa = longint'(signed'(val[23:0]));
      dik_pkg::REG_OFFSET_B:  geo_ob = longint'(signed'(val[23:0]));
      dik_pkg::REG_OFFSET_C:  geo_oc = longint'(signed'(val[23:0]));
      dik_pkg::REG_WIN0:      geo_win[0] = val;
      dik_pkg::REG_WIN1:      geo_win[1] = val;
      dik_pkg::REG_WIN2:      geo_win[2] = val;
      default: ;
    endcase
  endtask

  // Realistic geometry, lengths in mm scaled to Q15.8
  task automatic set_geometry(int upper_mm, int lower_mm, int a_mm, int b_mm, int c_mm);
    write_reg(dik_pkg::REG_UPPER_LEG, 32'(upper_mm * 256));
    write_reg(dik_pkg::REG_LOWER_LEG, 32'(lower_mm * 256));
    write_reg(dik_pkg::REG_OFFSET_A, 32'(a_mm * 256));
    write_reg(dik_pkg::REG_OFFSET_B, 32'(b_mm * 256));
    write_reg(dik_pkg::REG_OFFSET_C, 32'(c_mm * 256));
  endtask

  function automatic dik_pkg::in_item_t mk_point(int x, int y, int z);
    dik_pkg::in_item_t p;
    p.target_x = x[23:0];
    p.target_y = y[23:0];
    p.target_z = z[23:0];
    return p;
  endfunction

  // Mostly points near the workspace, some anywhere in the field range
  function automatic dik_pkg::in_item_t random_point();
    if ($urandom_range(9) < 8)
      return mk_point($urandom_range(120000) - 60000, $urandom_range(120000) - 60000,
                      -int'($urandom_range(100000)));
    return mk_point($urandom, $urandom, $urandom);
  endfunction

  task automatic run_random(int count, int idle, int stall);
    sender_idle_pct = idle;
    stall_pct = stall;
    repeat (count) point_q.push_back(random_point());
    drain();
  endtask

  initial begin
    geo_upper = 0; geo_lower = 0; geo_oa = 0; geo_ob = 0; geo_oc = 0;
    for (int j = 0; j < 3; j++) begin
      geo_win[j] = dik_pkg::WIN_RESET;
      held_angle[j] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero geometry after reset: zero vector case
    point_q.push_back(mk_point(0, 0, 0));
    point_q.push_back(mk_point(-8388608, 8388607, -8388608));
    drain();

    // Directed: field extremes, out of reach, windows narrow and inverted
    set_geometry(100, 250, 40, 10, 30);
    point_q.push_back(mk_point(0, 0, -200 * 256));
    point_q.push_back(mk_point(8388607, 8388607, 8388607));
    point_q.push_back(mk_point(-8388608, -8388608, -8388608));
    point_q.push_back(mk_point(0, 0, 0));
    point_q.push_back(mk_point(20 * 256, -15 * 256, -220 * 256));
    point_q.push_back(mk_point(1, -1, -1));
    drain();
    write_reg(dik_pkg::REG_WIN0, 32'h4000_C000);
    write_reg(dik_pkg::REG_WIN1, 32'h0000_8000);
    write_reg(dik_pkg::REG_WIN2, 32'h1000_2000);
    point_q.push_back(mk_point(0, 0, -200 * 256));
    point_q.push_back(mk_point(30 * 256, 30 * 256, -180 * 256));
    point_q.push_back(mk_point(-30 * 256, 10 * 256, -240 * 256));
    drain();
    write_reg(dik_pkg::REG_WIN0, 32'h0000_FFFF);
    write_reg(dik_pkg::REG_WIN1, 32'hFFFF_FFFF);
    write_reg(dik_pkg::REG_WIN2, 32'h0000_0000);
    point_q.push_back(mk_point(0, 0, -200 * 256));
    point_q.push_back(mk_point(10 * 256, -10 * 256, -210 * 256));
    drain();
    write_reg(dik_pkg::REG_UPPER_LEG, 32'h007F_FFFF);
    write_reg(dik_pkg::REG_LOWER_LEG, 32'h007F_FFFF);
    write_reg(dik_pkg::REG_OFFSET_A, 32'h0080_0000);
    write_reg(dik_pkg::REG_OFFSET_B, 32'h007F_FFFF);
    write_reg(dik_pkg::REG_OFFSET_C, 32'h0080_0000);
    point_q.push_back(mk_point(8388607, -8388608, 8388607));
    point_q.push_back(mk_point(-8388608, 8388607, -8388608));
    point_q.push_back(mk_point(0, 0, -1));
    drain();

    // Random phases across idle mixes and geometries
    set_geometry(100, 250, 40, 10, 30);
    for (int j = 0; j < 3; j++) write_reg(dik_pkg::REG_WIN0 + 3'(j), dik_pkg::WIN_RESET);
    run_random(300, 0, 0);
    run_random(300, 69, 0);
    set_geometry(80, 300, -20, 25, 15);
    write_reg(dik_pkg::REG_WIN0, 32'hC000_4000);
    write_reg(dik_pkg::REG_WIN1, {16'($urandom), 16'h0000});
    write_reg(dik_pkg::REG_WIN2, 32'h8000_2000);
    run_random(300, 0, 69);
    write_reg(dik_pkg::REG_UPPER_LEG, $urandom);
    write_reg(dik_pkg::REG_LOWER_LEG, $urandom);
    write_reg(dik_pkg::REG_OFFSET_A, $urandom);
    write_reg(dik_pkg::REG_OFFSET_B, $urandom);
    write_reg(dik_pkg::REG_OFFSET_C, $urandom);
    run_random(100, 37, 37);
    set_geometry(150, 350, 60, -30, 45);
    for (int j = 0; j < 3; j++) write_reg(dik_pkg::REG_WIN0 + 3'(j), dik_pkg::WIN_RESET);
    run_random(280, 37, 37);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/dik_pkg.sv
hdl/delta_inverse_kinematics_top.sv
dv/delta_inverse_kinematics_top_tb.sv
